FILE: src/ascm_pkg.sv
// ----------------------------------------------------------------------------
// ascm_pkg: shared types and constants of the adaptive symbol count model
// Widths, register indexes, the count store request and a saturating add.
// ----------------------------------------------------------------------------
package ascm_pkg;

   // Number of count entries held in the table.
   localparam int MAX_SYMBOLS = 256;
   localparam int ADDR_W      = $clog2(MAX_SYMBOLS);
   // Wide enough to hold MAX_SYMBOLS itself.
   localparam int CTR_W       = ADDR_W + 1;

   localparam int SYM_W       = 8;
   localparam int CNT_W       = 25;
   localparam int ALPHA_W     = 9;
   localparam int STEP_W      = 8;
   localparam int LIMIT_W     = 24;
   localparam int CMP_W       = (CTR_W > ALPHA_W) ? CTR_W : ALPHA_W;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   // Reset values of the configuration registers and of the total.
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(256);
   localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(8);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);
   localparam logic [CNT_W-1:0]   TOTAL_RESET =
      CNT_W'((256 < MAX_SYMBOLS) ? 256 : MAX_SYMBOLS);

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = LIMIT_W;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHABET_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_STEP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESCALE_LIMIT = 2'd2;

   // Stream payload widths.
   localparam int REQ_TDATA_W = SYM_W;
   localparam int RSP_TDATA_W = ((2 * CNT_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - 2 * CNT_W;
   localparam int RSP_TUSER_W = 2;

   // Input kind codes.
   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_REINIT = 1'b1;

   // Response status codes.
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   // Access request to the count store.
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CNT_W-1:0]  wr_data;
      logic              clear;
   } store_req_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
   endfunction

endpackage

FILE: src/adaptive_symbol_count_model.sv
// ----------------------------------------------------------------------------
// adaptive_symbol_count_model: adaptive frequency table with halving
// An update, a rejected symbol or a reinitialise is taken in IDLE and gives
// its result from EXEC; an update that rescales goes on through SWEEP, with
// one table read per cycle over the alphabet in use. A new item is taken
// only once the last one's result is out, set by the read-modify-write of the
// count RAM. Reset is synchronous; counts read as one at once through the
// valid bits of the store, so there is no clearing pass.
// ----------------------------------------------------------------------------
module adaptive_symbol_count_model (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ascm_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [7:0] symbol
   input  logic                                req_tuser,   // [0] kind
   // Response stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ascm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [24:0] symbol_count,
                                                            // [49:25] total_count
   output logic [ascm_pkg::RSP_TUSER_W-1:0]    rsp_tuser,   // [0] rescaled, [1] status
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [ascm_pkg::CSR_IDX_W-1:0]      csr_addr,
   input  logic [ascm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ascm_pkg::*;

   // The control is a small one-hot sequencer. IDLE takes a request and
   // starts the read of its count; EXEC sees the read data and either
   // finishes or starts a rescale; SWEEP walks the alphabet with one read
   // issued and one halved count written back per cycle; HOLD keeps a result
   // while the response register is still occupied.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_SWEEP = 4'b0100,
      ST_HOLD  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;

   // Configuration registers.
   logic [ALPHA_W-1:0]  alpha_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [LIMIT_W-1:0]  limit_ff;

   // Item in flight.
   logic                kind_ff, kind_in;
   logic [SYM_W-1:0]    sym_ff, sym_in;

   // Running total and rescale sweep state.
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [CTR_W-1:0]    ctr_ff, ctr_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   widx_ff, widx_in;
   logic [CNT_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    symcnt_ff, symcnt_in;

   // Result held while the response register is busy.
   logic [CNT_W-1:0]    hold_cnt_ff, hold_cnt_in;
   logic [CNT_W-1:0]    hold_tot_ff, hold_tot_in;
   logic                hold_rsc_ff, hold_rsc_in;
   logic                hold_sts_ff, hold_sts_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   logic [CNT_W-1:0]    rsp_tot_ff, rsp_tot_in;
   logic                rsp_rsc_ff, rsp_rsc_in;
   logic                rsp_sts_ff, rsp_sts_in;

   store_req_type       store_req;
   logic [CNT_W-1:0]    rd_data;

   logic [ALPHA_W-1:0]  n_eff;
   logic                out_free;
   logic                req_xfer;

   // Result produced this cycle, before it goes to the response register.
   logic                res_go;
   logic [CNT_W-1:0]    res_cnt;
   logic [CNT_W-1:0]    res_tot;
   logic                res_rsc;
   logic                res_sts;

   logic [CNT_W-1:0]    step_ext;
   logic [CNT_W-1:0]    new_cnt;
   logic [CNT_W-1:0]    new_tot;
   logic [CNT_W-1:0]    half_cnt;

   ascm_store u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (store_req),
      .rd_data (rd_data)
   );

   // The alphabet in use is the register capped at the table depth.
   assign n_eff = (32'(alpha_ff) > MAX_SYMBOLS) ? ALPHA_W'(MAX_SYMBOLS) : alpha_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign step_ext = CNT_W'(step_ff);
   assign new_cnt  = sat_add(rd_data, step_ext);
   assign new_tot  = sat_add(total_ff, step_ext);
   // Halve and add one; a zero count stays zero.
   assign half_cnt = (rd_data != '0) ? ((rd_data >> 1) + CNT_ONE) : rd_data;

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      sym_in      = sym_ff;
      total_in    = total_ff;
      ctr_in      = ctr_ff;
      pend_in     = 1'b0;
      widx_in     = widx_ff;
      sum_in      = sum_ff;
      symcnt_in   = symcnt_ff;
      store_req   = '0;
      res_go      = 1'b0;
      res_cnt     = '0;
      res_tot     = total_ff;
      res_rsc     = 1'b0;
      res_sts     = STATUS_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               kind_in           = req_tuser;
               sym_in            = req_tdata;
               store_req.rd_en   = 1'b1;
               store_req.rd_addr = ADDR_W'(req_tdata);
               state_in          = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (kind_ff == KIND_REINIT) begin
               // Every count back to one, the total to the alphabet in use.
               store_req.clear = 1'b1;
               total_in        = CNT_W'(n_eff);
               res_go          = 1'b1;
               res_tot         = CNT_W'(n_eff);
            end else if (CMP_W'(sym_ff) >= CMP_W'(n_eff)) begin
               // Symbol outside the alphabet: nothing changes.
               res_go  = 1'b1;
               res_sts = STATUS_REJECTED;
            end else begin
               store_req.wr_en   = 1'b1;
               store_req.wr_addr = ADDR_W'(sym_ff);
               store_req.wr_data = new_cnt;
               total_in          = new_tot;
               if (new_tot > CNT_W'(limit_ff)) begin
                  // The sweep starts only after this write, so that its read of this
                  // symbol sees the count written here.
                  ctr_in   = '0;
                  sum_in   = '0;
                  state_in = ST_SWEEP;
               end else begin
                  res_go  = 1'b1;
                  res_cnt = new_cnt;
                  res_tot = new_tot;
               end
            end
         end

         ST_SWEEP: begin
            // Issue side: one read per cycle over the alphabet.
            if (CMP_W'(ctr_ff) < CMP_W'(n_eff)) begin
               store_req.rd_en   = 1'b1;
               store_req.rd_addr = ctr_ff[ADDR_W-1:0];
               widx_in           = ctr_ff[ADDR_W-1:0];
               pend_in           = 1'b1;
               ctr_in            = ctr_ff + CTR_W'(1);
            end
            // Write-back side: the entry read in the previous cycle.
            if (pend_ff) begin
               store_req.wr_en   = 1'b1;
               store_req.wr_addr = widx_ff;
               store_req.wr_data = half_cnt;
               if (rd_data != '0) begin
                  sum_in = sat_add(sum_ff, half_cnt);
               end
               if (widx_ff == ADDR_W'(sym_ff)) begin
                  symcnt_in = half_cnt;
               end
            end else if (CMP_W'(ctr_ff) >= CMP_W'(n_eff)) begin
               total_in = sum_ff;
               res_go   = 1'b1;
               res_cnt  = symcnt_ff;
               res_tot  = sum_ff;
               res_rsc  = 1'b1;
            end
         end

         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (res_go) begin
         state_in = out_free ? ST_IDLE : ST_HOLD;
      end
   end

   // Result routing: straight into the response register when it is free,
   // otherwise parked in the hold register until the transfer frees it.
   always_comb begin
      hold_cnt_in  = hold_cnt_ff;
      hold_tot_in  = hold_tot_ff;
      hold_rsc_in  = hold_rsc_ff;
      hold_sts_in  = hold_sts_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_tot_in   = rsp_tot_ff;
      rsp_rsc_in   = rsp_rsc_ff;
      rsp_sts_in   = rsp_sts_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (res_go && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_cnt_in   = res_cnt;
         rsp_tot_in   = res_tot;
         rsp_rsc_in   = res_rsc;
         rsp_sts_in   = res_sts;
      end else if (res_go) begin
         hold_cnt_in  = res_cnt;
         hold_tot_in  = res_tot;
         hold_rsc_in  = res_rsc;
         hold_sts_in  = res_sts;
      end else if ((state_ff == ST_HOLD) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_cnt_in   = hold_cnt_ff;
         rsp_tot_in   = hold_tot_ff;
         rsp_rsc_in   = hold_rsc_ff;
         rsp_sts_in   = hold_sts_ff;
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= TOTAL_RESET;
         pend_ff      <= 1'b0;
         alpha_ff     <= ALPHA_RESET;
         step_ff      <= STEP_RESET;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         pend_ff      <= pend_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_ALPHABET_SIZE: alpha_ff <= csr_wdata[ALPHA_W-1:0];
               CSR_COUNT_STEP:    step_ff  <= csr_wdata[STEP_W-1:0];
               CSR_RESCALE_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      sym_ff      <= sym_in;
      ctr_ff      <= ctr_in;
      widx_ff     <= widx_in;
      sum_ff      <= sum_in;
      symcnt_ff   <= symcnt_in;
      hold_cnt_ff <= hold_cnt_in;
      hold_tot_ff <= hold_tot_in;
      hold_rsc_ff <= hold_rsc_in;
      hold_sts_ff <= hold_sts_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_tot_ff  <= rsp_tot_in;
      rsp_rsc_ff  <= rsp_rsc_in;
      rsp_sts_ff  <= rsp_sts_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_tot_ff, rsp_cnt_ff};
   assign rsp_tuser  = {rsp_sts_ff, rsp_rsc_ff};

endmodule

FILE: src/ascm_ram.sv
// ----------------------------------------------------------------------------
// ascm_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module ascm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ascm_store.sv
// ----------------------------------------------------------------------------
// ascm_store: symbol count store
// A RAM of counts plus one valid bit per entry; an entry that was never
// written since reset or the last clear reads as a count of one.
// ----------------------------------------------------------------------------
module ascm_store (
   input  logic                          clock,
   input  logic                          reset,
   input  ascm_pkg::store_req_type       req,
   output logic [ascm_pkg::CNT_W-1:0]    rd_data
);
   import ascm_pkg::*;

   logic [MAX_SYMBOLS-1:0] valid_ff;
   logic [MAX_SYMBOLS-1:0] valid_in;
   logic                   rd_valid_ff;
   logic [CNT_W-1:0]       ram_q;

   ascm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_SYMBOLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (req.wr_en),
      .wr_addr (req.wr_addr),
      .wr_data (req.wr_data),
      .rd_en   (req.rd_en),
      .rd_addr (req.rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (req.clear) begin
         valid_in = '0;
      end else if (req.wr_en) begin
         valid_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req.rd_en) begin
         rd_valid_ff <= valid_ff[req.rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? ram_q : CNT_ONE;

endmodule
